@@ hw/rtl/sws_pkg.sv @@
// Package for the sliding window sender: sizes, command and event codes,
// payload and control structs, and the slot mask helper.
// No dependencies.
package sws_pkg;

  localparam int unsigned WINDOW_SLOTS      = 32;
  localparam int unsigned SLOT_W            = $clog2(WINDOW_SLOTS);
  localparam logic [15:0] FULL_PAYLOAD      = 16'd1400;
  localparam logic [7:0]  RESET_RETRY_LIMIT = 8'd100;
  localparam logic [7:0]  SILENT_MAX        = 8'hFF;

  typedef logic [WINDOW_SLOTS-1:0] slot_map_t;
  typedef logic [SLOT_W-1:0]       slot_idx_t;

  typedef enum logic [1:0] {
    CMD_CUM_ACK = 2'd0,
    CMD_SEL_ACK = 2'd1,
    CMD_END     = 2'd2,
    CMD_TICK    = 2'd3
  } sws_command_e;

  typedef enum logic [1:0] {
    EV_SEND  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } sws_event_e;

  typedef struct packed {
    sws_command_e command;
    logic [31:0]  ack_sequence;
    logic [31:0]  end_sequence;
    logic [15:0]  end_length;
  } sws_in_t;

  typedef struct packed {
    sws_event_e  event_kind;
    logic [31:0] sequence_res;
    logic        is_final;
    logic [15:0] payload_length;
    logic        last;
  } sws_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic slide;
    logic prep;
    logic scan;
  } sws_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic abort;
    logic slide_more;
    logic scan_last;
  } sws_sts_t;

  // Mask with slots 0 up to and including n set.
  function automatic slot_map_t slots_upto(slot_idx_t n);
    slot_map_t m;
    for (int k = 0; k < int'(WINDOW_SLOTS); k++) begin
      m[k] = (k <= int'(n));
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/sws_datapath.sv @@
// Datapath of the sliding window sender: window state, retry register,
// slide and scan registers, and the registered result word.
// Depends on sws_pkg.
module sws_datapath import sws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sws_ctl_t ctl_i,
  output sws_sts_t sts_o,
  input  sws_in_t  item_i,
  input  logic     cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output logic     result_strobe_o,
  output sws_out_t result_o
);

  logic [7:0]  retry_q, retry_d;
  logic [31:0] base_q, base_d;
  slot_map_t   map_q, map_d;
  logic        end_known_q, end_known_d;
  logic [31:0] final_seq_q, final_seq_d;
  logic [15:0] final_len_q, final_len_d;
  logic [7:0]  silent_q, silent_d;
  logic        ack_seen_q, ack_seen_d;
  slot_map_t   pend_q, pend_d;
  logic [31:0] seq_q, seq_d;
  slot_idx_t   idx_q, idx_d;
  slot_idx_t   fo_idx_q, fo_idx_d;
  logic        fin_in_q, fin_in_d;
  logic        strobe_q, strobe_d;
  sws_out_t    res_q, res_d;

  logic [31:0] ack_off;
  logic        ack_in_win;
  logic [31:0] fo;
  logic        fo_in_win;
  logic [7:0]  silent_tick;

  assign ack_off    = item_i.ack_sequence - base_q;
  assign ack_in_win = ack_off < 32'(WINDOW_SLOTS);
  assign fo         = final_seq_q - base_q;
  assign fo_in_win  = end_known_q && (fo < 32'(WINDOW_SLOTS));
  assign silent_tick = ack_seen_q ? 8'd0 :
                       ((silent_q == SILENT_MAX) ? SILENT_MAX : silent_q + 8'd1);

  assign sts_o.abort      = silent_tick > retry_q;
  assign sts_o.slide_more = map_q[0] && !(end_known_q && (base_q == final_seq_q));
  assign sts_o.scan_last  = (pend_q[WINDOW_SLOTS-1:1] == '0);

  always_comb begin
    retry_d     = retry_q;
    base_d      = base_q;
    map_d       = map_q;
    end_known_d = end_known_q;
    final_seq_d = final_seq_q;
    final_len_d = final_len_q;
    silent_d    = silent_q;
    ack_seen_d  = ack_seen_q;
    pend_d      = pend_q;
    seq_d       = seq_q;
    idx_d       = idx_q;
    fo_idx_d    = fo_idx_q;
    fin_in_d    = fin_in_q;
    strobe_d    = 1'b0;
    res_d       = res_q;

    if (cfg_we_i) begin
      retry_d = cfg_data_i;
    end

    if (ctl_i.accept) begin
      case (item_i.command)
        CMD_CUM_ACK: begin
          ack_seen_d = 1'b1;
          if (ack_in_win) begin
            map_d = map_q | slots_upto(ack_off[SLOT_W-1:0]);
          end
        end
        CMD_SEL_ACK: begin
          ack_seen_d = 1'b1;
          if (ack_in_win) begin
            map_d[ack_off[SLOT_W-1:0]] = 1'b1;
          end
        end
        CMD_END: begin
          end_known_d = 1'b1;
          final_seq_d = item_i.end_sequence;
          final_len_d = item_i.end_length;
        end
        CMD_TICK: begin
          silent_d   = silent_tick;
          ack_seen_d = 1'b0;
          if (sts_o.abort) begin
            strobe_d             = 1'b1;
            res_d.event_kind     = EV_ABORT;
            res_d.sequence_res   = '0;
            res_d.is_final       = 1'b0;
            res_d.payload_length = '0;
            res_d.last           = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (ctl_i.slide) begin
      map_d  = map_q >> 1;
      base_d = base_q + 32'd1;
    end

    if (ctl_i.prep) begin
      pend_d   = ~map_q & (fo_in_win ? slots_upto(fo[SLOT_W-1:0]) : '1);
      seq_d    = base_q;
      idx_d    = '0;
      fo_idx_d = fo[SLOT_W-1:0];
      fin_in_d = fo_in_win;
    end

    if (ctl_i.scan) begin
      if (pend_q == '0) begin
        strobe_d             = 1'b1;
        res_d.event_kind     = EV_DONE;
        res_d.sequence_res   = '0;
        res_d.is_final       = 1'b0;
        res_d.payload_length = '0;
        res_d.last           = 1'b1;
      end else if (pend_q[0]) begin
        strobe_d             = 1'b1;
        res_d.event_kind     = EV_SEND;
        res_d.sequence_res   = seq_q;
        res_d.is_final       = fin_in_q && (idx_q == fo_idx_q);
        res_d.payload_length = (fin_in_q && (idx_q == fo_idx_q)) ? final_len_q
                                                                 : FULL_PAYLOAD;
        res_d.last           = sts_o.scan_last;
      end
      pend_d = pend_q >> 1;
      seq_d  = seq_q + 32'd1;
      idx_d  = idx_q + slot_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q     <= RESET_RETRY_LIMIT;
      base_q      <= '0;
      map_q       <= '0;
      end_known_q <= 1'b0;
      final_seq_q <= '0;
      final_len_q <= '0;
      silent_q    <= '0;
      ack_seen_q  <= 1'b1;
      strobe_q    <= 1'b0;
    end else begin
      retry_q     <= retry_d;
      base_q      <= base_d;
      map_q       <= map_d;
      end_known_q <= end_known_d;
      final_seq_q <= final_seq_d;
      final_len_q <= final_len_d;
      silent_q    <= silent_d;
      ack_seen_q  <= ack_seen_d;
      strobe_q    <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    seq_q    <= seq_d;
    idx_q    <= idx_d;
    fo_idx_q <= fo_idx_d;
    fin_in_q <= fin_in_d;
    res_q    <= res_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

endmodule

@@ hw/rtl/sws_ctrl.sv @@
// Controller of the sliding window sender: sequences a round tick through
// the slide, preparation and scan steps of the datapath.
// Depends on sws_pkg.
module sws_ctrl import sws_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  sws_command_e command_i,
  input  sws_sts_t     sts_i,
  output sws_ctl_t     ctl_o,
  output logic         busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLIDE,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          if ((command_i == CMD_TICK) && !sts_i.abort) begin
            state_d = ST_SLIDE;
            busy_d  = 1'b1;
          end
        end
      end
      ST_SLIDE: begin
        if (sts_i.slide_more) begin
          ctl_o.slide = 1'b1;
        end else begin
          ctl_o.prep = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_IDLE;
          busy_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

@@ hw/rtl/sliding_window_sender.sv @@
// Timing: an ack or end-of-data word is taken in idle and produces no result.
// A round tick that aborts gives its result in the cycle after acceptance; otherwise it
// runs through S slides (0 to 32), a preparation step and N scan steps (1 to 32),
// one slot per cycle, and busy stays high meanwhile. Results cannot be stalled.
// Reset (asynchronous, active low) clears the window and sets the retry limit to 100.
// Top level of the sliding window sender; depends on sws_pkg, sws_ctrl, sws_datapath.
module sliding_window_sender import sws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  sws_in_t    item_i,
  output logic       result_strobe_o,
  output sws_out_t   result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  sws_ctl_t ctl;
  sws_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sws_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (item_i.command),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .busy      (busy)
  );

  sws_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .item_i          (item_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule

@@ hw/rtl/sws_checker.sv @@
// Port-level checks for the sliding window sender, bound to the top level.
// Depends on sws_pkg and sliding_window_sender.
module sws_checker import sws_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input sws_in_t  item_i,
  input logic     result_strobe_o,
  input sws_out_t result_o
);

  a_other_kinds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (result_o.event_kind != EV_SEND) |-> result_o.last)
    else $error("completion or abort word not marked last");

  a_more_means_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !result_o.last |-> busy)
    else $error("further words promised while idle");

  a_final_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.is_final |-> result_o.last)
    else $error("final packet word not last of its tick");

  a_short_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (item_i.command != CMD_TICK) |=> !busy)
    else $error("ack or end-of-data word left the block busy");

endmodule

bind sliding_window_sender sws_checker u_sws_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .item_i          (item_i),
  .result_strobe_o (result_strobe_o),
  .result_o        (result_o)
);

@@ sim/tb_sliding_window_sender.sv @@
// Self-checking testbench for the sliding window sender: directed and random command
// words with random start gaps, checked against an in-bench window predictor.
// Depends on sws_pkg and the sliding_window_sender RTL.
`timescale 1ns / 100ps

module tb_sliding_window_sender;
  import sws_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned PHASE_WORDS  = 66;

  typedef struct packed {
    logic [31:0] base;
    slot_map_t   acked;
    logic        end_known;
    logic [31:0] fin_seq;
    logic [15:0] fin_len;
    logic [7:0]  silent;
    logic        ack_seen;
    logic [7:0]  limit;
  } win_state_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  sws_in_t    item_i = '0;
  logic       result_strobe_o;
  sws_out_t   result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  sws_in_t     pending_words[$];
  sws_out_t    expected_events[$];
  win_state_t  dut_window;
  win_state_t  plan_window;
  sws_out_t    step_events[WINDOW_SLOTS];
  int          step_count;
  int unsigned accepted_words = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  limits[7];

  sliding_window_sender u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic win_state_t window_reset();
    win_state_t s;
    s          = '0;
    s.ack_seen = 1'b1;
    s.limit    = RESET_RETRY_LIMIT;
    return s;
  endfunction

  function automatic void advance_window(inout win_state_t s, input sws_in_t it,
                                         output sws_out_t ev[WINDOW_SLOTS], output int n);
    logic [31:0] off;
    logic [31:0] fo;
    logic        fin;
    n = 0;
    for (int k = 0; k < int'(WINDOW_SLOTS); k++) ev[k] = '0;
    off = it.ack_sequence - s.base;
    case (it.command)
      CMD_CUM_ACK: begin
        s.ack_seen = 1'b1;
        if (off < WINDOW_SLOTS) begin
          for (int k = 0; k < int'(WINDOW_SLOTS); k++) begin
            if (32'(k) <= off) s.acked[k] = 1'b1;
          end
        end
      end
      CMD_SEL_ACK: begin
        s.ack_seen = 1'b1;
        if (off < WINDOW_SLOTS) s.acked[off[SLOT_W-1:0]] = 1'b1;
      end
      CMD_END: begin
        s.end_known = 1'b1;
        s.fin_seq   = it.end_sequence;
        s.fin_len   = it.end_length;
      end
      default: begin
        if (!s.ack_seen) begin
          if (s.silent != SILENT_MAX) s.silent = s.silent + 8'd1;
        end else begin
          s.silent = '0;
        end
        s.ack_seen = 1'b0;
        if (s.silent > s.limit) begin
          ev[0].event_kind = EV_ABORT;
          ev[0].last       = 1'b1;
          n = 1;
          return;
        end
        for (int k = 0; k < int'(WINDOW_SLOTS); k++) begin
          if (!s.acked[0] || (s.end_known && s.base == s.fin_seq)) break;
          s.acked = s.acked >> 1;
          s.base  = s.base + 32'd1;
        end
        fo = s.fin_seq - s.base;
        for (int k = 0; k < int'(WINDOW_SLOTS); k++) begin
          if (s.end_known && fo < WINDOW_SLOTS && 32'(k) > fo) break;
          if (s.acked[k]) continue;
          fin = s.end_known && (32'(k) == fo);
          ev[n].event_kind     = EV_SEND;
          ev[n].sequence_res   = s.base + 32'(k);
          ev[n].is_final       = fin;
          ev[n].payload_length = fin ? s.fin_len : FULL_PAYLOAD;
          n++;
        end
        if (n == 0) begin
          ev[0].event_kind = EV_DONE;
          n = 1;
        end
        ev[n-1].last = 1'b1;
      end
    endcase
  endfunction

  task automatic push_word(input sws_command_e cmd, input logic [31:0] ack_seq,
                           input logic [31:0] end_seq, input logic [15:0] end_len);
    sws_in_t  it;
    sws_out_t scratch[WINDOW_SLOTS];
    int       n;
    it.command      = cmd;
    it.ack_sequence = ack_seq;
    it.end_sequence = end_seq;
    it.end_length   = end_len;
    advance_window(plan_window, it, scratch, n);
    pending_words.push_back(it);
  endtask

  function automatic logic [31:0] near_base(input int unsigned span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return plan_window.base + $urandom_range(0, span);
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0 || start || expected_events.size() != 0 || busy)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i       <= 1'b0;
    dut_window.limit  = value;
    plan_window.limit = value;
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned pick;
    logic [15:0] len;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                       : 16'($urandom);
      if (pick < 30) begin
        push_word(CMD_CUM_ACK, near_base(36), $urandom, 16'($urandom));
      end else if (pick < 55) begin
        push_word(CMD_SEL_ACK, near_base(36), $urandom, 16'($urandom));
      end else if (pick < 63) begin
        if ($urandom_range(0, 9) == 0)
          push_word(CMD_END, $urandom, plan_window.base - $urandom_range(1, 5), len);
        else
          push_word(CMD_END, $urandom, near_base(40), len);
      end else if (pick < 67) begin
        if (plan_window.end_known)
          push_word(CMD_CUM_ACK, plan_window.fin_seq, $urandom, 16'($urandom));
        push_word(CMD_TICK, $urandom, $urandom, 16'($urandom));
      end else if (pick < 72) begin
        repeat ($urandom_range(2, 5)) push_word(CMD_TICK, $urandom, $urandom, 16'($urandom));
      end else begin
        push_word(CMD_TICK, $urandom, $urandom, 16'($urandom));
      end
    end
  endtask

  // Driver: presents the oldest pending word and predicts it when accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        advance_window(dut_window, item_i, step_events, step_count);
        for (int k = 0; k < step_count; k++) expected_events.push_back(step_events[k]);
        void'(pending_words.pop_front());
        accepted_words++;
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 &&
            ((accepted_words >= 150 && accepted_words < 260) ||
             $urandom_range(0, 99) >= 29)) begin
          start  <= 1'b1;
          item_i <= pending_words[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected event.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result kind=%0d seq=%h fin=%b len=%0d last=%b", $time,
                 result_o.event_kind, result_o.sequence_res, result_o.is_final,
                 result_o.payload_length, result_o.last);
        mismatch_cnt++;
      end else begin
        if (result_o.event_kind !== expected_events[0].event_kind ||
            result_o.sequence_res !== expected_events[0].sequence_res ||
            result_o.is_final !== expected_events[0].is_final ||
            result_o.payload_length !== expected_events[0].payload_length ||
            result_o.last !== expected_events[0].last) begin
          $display("%0t: mismatch expected kind=%0d seq=%h fin=%b len=%0d last=%b", $time,
                   expected_events[0].event_kind, expected_events[0].sequence_res,
                   expected_events[0].is_final, expected_events[0].payload_length,
                   expected_events[0].last);
          $display("%0t:          actual   kind=%0d seq=%h fin=%b len=%0d last=%b", $time,
                   result_o.event_kind, result_o.sequence_res, result_o.is_final,
                   result_o.payload_length, result_o.last);
          mismatch_cnt++;
        end
        void'(expected_events.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dut_window  = window_reset();
    plan_window = window_reset();
    limits      = '{8'd1, 8'd255, 8'd3, 8'd1, 8'($urandom_range(1, 255)), 8'd255, 8'd2};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_limit(limits[0]);
    // The first tick is never silent, so it lists the whole window.
    push_word(CMD_TICK, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(CMD_SEL_ACK, 32'hFFFF_FFFF, 32'h0, 16'h0);
    push_word(CMD_SEL_ACK, 32'd31, 32'h0, 16'h0);
    push_word(CMD_CUM_ACK, 32'd0, 32'h0, 16'h0);
    push_word(CMD_TICK, 32'hFFFF_FFFF, 32'h0, 16'h0);
    push_word(CMD_END, 32'h0, 32'd5, 16'h0000);
    push_word(CMD_SEL_ACK, 32'd3, 32'h0, 16'h0);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    // Silent ticks: the second one exceeds the limit, and the next aborts again.
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    // A final sequence far away or behind the base leaves every slot in play.
    push_word(CMD_END, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(CMD_CUM_ACK, 32'hFFFF_FFFF, 32'h0, 16'h0);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    push_word(CMD_END, 32'h0, 32'h0, 16'h1234);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    push_word(CMD_END, 32'h0, plan_window.base + 32'd40, 16'hFFFF);
    push_word(CMD_CUM_ACK, plan_window.base + 32'd31, 32'h0, 16'h0);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    // Everything up to the final packet acknowledged: the window completes.
    push_word(CMD_END, 32'h0, plan_window.base + 32'd3, 16'd7);
    push_word(CMD_CUM_ACK, plan_window.base + 32'd3, 32'h0, 16'h0);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    push_word(CMD_END, 32'h5555_AAAA, 32'hAAAA_5555, 16'h5A5A);
    push_word(CMD_TICK, 32'h0, 32'h0, 16'h0);

    for (int p = 1; p < 7; p++) begin
      wait_idle();
      write_limit(limits[p]);
      random_phase(PHASE_WORDS);
    end

    wait_idle();
    if (mismatch_cnt == 0 && expected_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sliding_window_sender.f @@
hw/rtl/sws_pkg.sv
hw/rtl/sws_datapath.sv
hw/rtl/sws_ctrl.sv
hw/rtl/sliding_window_sender.sv
hw/rtl/sws_checker.sv
sim/tb_sliding_window_sender.sv
